// File: rtl/core/jsj_pkg.sv
`default_nettype none

package jsj_pkg;

  localparam int unsigned ServoCount = 6;
  localparam int unsigned AxisW      = 12;
  localparam int unsigned AngleW     = 8;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned LimitsW    = ServoCount * AngleW;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = LimitsW;

  localparam logic [AxisW-1:0]   HighThReset  = AxisW'(3000);
  localparam logic [AxisW-1:0]   LowThReset   = AxisW'(1000);
  localparam logic [PeriodW-1:0] PeriodReset  = PeriodW'(40);
  localparam logic [AngleW-1:0]  TargetReset  = AngleW'(90);
  localparam logic [AngleW-1:0]  MaxAngleRst  = AngleW'(180);
  localparam logic [LimitsW-1:0] MinAnglesRst = '0;
  localparam logic [LimitsW-1:0] MaxAnglesRst = {ServoCount{MaxAngleRst}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HIGH_THRESHOLD = 3'd0,
    CFG_LOW_THRESHOLD  = 3'd1,
    CFG_UPDATE_PERIOD  = 3'd2,
    CFG_MIN_ANGLES     = 3'd3,
    CFG_MAX_ANGLES     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [AxisW-1:0] left_x;
    logic [AxisW-1:0] left_y;
    logic [AxisW-1:0] right_x;
    logic [AxisW-1:0] right_y;
    logic             left_button;
    logic             right_button;
    logic             auto_button;
    logic             emergency_stop;
  } in_item_t;

  typedef struct packed {
    logic [AngleW-1:0] target_0;
    logic [AngleW-1:0] target_1;
    logic [AngleW-1:0] target_2;
    logic [AngleW-1:0] target_3;
    logic [AngleW-1:0] target_4;
    logic [AngleW-1:0] target_5;
    logic              move_request;
    logic              auto_active;
    logic              buttons_drive_gripper;
  } out_item_t;

  // one degree step, raised to lo first, then lowered to hi
  function automatic logic [AngleW-1:0] jog(input logic [AngleW-1:0] cur,
                                            input logic              up,
                                            input logic [AngleW-1:0] lo,
                                            input logic [AngleW-1:0] hi);
    logic signed [AngleW+1:0] v;
    v = up ? $signed({2'b00, cur}) + 10'sd1 : $signed({2'b00, cur}) - 10'sd1;
    if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
    if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
    return v[AngleW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/joystick_servo_jog.sv
`default_nettype none

// Joystick jog controller for a six-servo arm. One input transaction is one
// millisecond tick and yields exactly one result transaction carrying all six
// servo targets and the mode flags. The block takes one transaction per clock
// cycle while in_stall_o is low; the state update and result are computed
// combinationally and the result is registered. A two-entry output
// register lets one more tick enter while a result is stalled, and in_stall_o
// rises only when both entries are full. Configuration writes are always
// ready and take effect on the next accepted tick; indexes past the last
// register are ignored.
module joystick_servo_jog (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire jsj_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output jsj_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [jsj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [jsj_pkg::CfgDataW-1:0]  cfg_data_i
);
  import jsj_pkg::*;

  logic [AxisW-1:0]   high_th_q;
  logic [AxisW-1:0]   low_th_q;
  logic [PeriodW-1:0] period_q;
  logic [LimitsW-1:0] min_angles_q;
  logic [LimitsW-1:0] max_angles_q;

  logic [AngleW-1:0]  targets_q [ServoCount];
  logic [AngleW-1:0]  targets_d [ServoCount];
  logic [PeriodW-1:0] wait_q, wait_d;
  logic               auto_q, auto_d;
  logic               ab_was_q, ab_was_d;
  logic               grip_q, grip_d;
  logic               both_was_q, both_was_d;

  logic               in_accept;
  logic               skid_full;
  logic               eval;
  logic               both;
  logic               changed;
  logic [3:0]         ax_step;
  logic [3:0]         ax_up;
  logic [AxisW-1:0]   ax_val [4];
  logic [AngleW-1:0]  lo_lim [ServoCount];
  logic [AngleW-1:0]  hi_lim [ServoCount];
  logic               btn_step;
  logic               btn_up;
  out_item_t          res;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !skid_full;
  assign in_stall_o  = skid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_th_q    <= HighThReset;
      low_th_q     <= LowThReset;
      period_q     <= PeriodReset;
      min_angles_q <= MinAnglesRst;
      max_angles_q <= MaxAnglesRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HIGH_THRESHOLD: high_th_q    <= cfg_data_i[AxisW-1:0];
        CFG_LOW_THRESHOLD:  low_th_q     <= cfg_data_i[AxisW-1:0];
        CFG_UPDATE_PERIOD:  period_q     <= cfg_data_i[PeriodW-1:0];
        CFG_MIN_ANGLES:     min_angles_q <= cfg_data_i[LimitsW-1:0];
        CFG_MAX_ANGLES:     max_angles_q <= cfg_data_i[LimitsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < ServoCount; i++) begin
      lo_lim[i] = min_angles_q[i*AngleW +: AngleW];
      hi_lim[i] = max_angles_q[i*AngleW +: AngleW];
    end
  end

  // servo 0..3 axis order; servo 1 steps down on a high reading
  assign ax_val[0] = in_data_i.left_x;
  assign ax_val[1] = in_data_i.left_y;
  assign ax_val[2] = in_data_i.right_y;
  assign ax_val[3] = in_data_i.right_x;

  always_comb begin
    auto_d     = (in_data_i.auto_button && !ab_was_q) ? !auto_q : auto_q;
    ab_was_d   = in_data_i.auto_button;
    eval       = !in_data_i.auto_button && !auto_d && (wait_q == '0) &&
                 !in_data_i.emergency_stop;
    both       = in_data_i.left_button && in_data_i.right_button;

    if (eval) begin
      wait_d = (period_q == '0) ? '0 : period_q - PeriodW'(1);
    end else if (wait_q != '0) begin
      wait_d = wait_q - PeriodW'(1);
    end else begin
      wait_d = wait_q;
    end

    grip_d     = (eval && both && !both_was_q) ? !grip_q : grip_q;
    both_was_d = eval ? both : both_was_q;

    for (int i = 0; i < 4; i++) begin
      logic hi_hit;
      logic lo_hit;
      hi_hit     = ax_val[i] > high_th_q;
      lo_hit     = ax_val[i] < low_th_q;
      ax_step[i] = hi_hit || lo_hit;
      ax_up[i]   = (i == 1) ? !hi_hit : hi_hit;
    end

    btn_step = !both && (in_data_i.left_button || in_data_i.right_button);
    btn_up   = grip_d ? in_data_i.left_button : in_data_i.right_button;

    for (int i = 0; i < ServoCount; i++) targets_d[i] = targets_q[i];
    if (eval) begin
      for (int i = 0; i < 4; i++) begin
        if (ax_step[i]) begin
          targets_d[i] = jog(targets_q[i], ax_up[i], lo_lim[i], hi_lim[i]);
        end
      end
      if (btn_step && !grip_d) begin
        targets_d[4] = jog(targets_q[4], btn_up, lo_lim[4], hi_lim[4]);
      end
      if (btn_step && grip_d) begin
        targets_d[5] = jog(targets_q[5], btn_up, lo_lim[5], hi_lim[5]);
      end
    end
    changed = eval && ((ax_step != '0) || btn_step);

    res.target_0              = targets_d[0];
    res.target_1              = targets_d[1];
    res.target_2              = targets_d[2];
    res.target_3              = targets_d[3];
    res.target_4              = targets_d[4];
    res.target_5              = targets_d[5];
    res.move_request          = changed;
    res.auto_active           = auto_d;
    res.buttons_drive_gripper = grip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ServoCount; i++) targets_q[i] <= TargetReset;
      wait_q     <= '0;
      auto_q     <= 1'b0;
      ab_was_q   <= 1'b0;
      grip_q     <= 1'b1;
      both_was_q <= 1'b0;
    end else if (in_accept) begin
      for (int i = 0; i < ServoCount; i++) targets_q[i] <= targets_d[i];
      wait_q     <= wait_d;
      auto_q     <= auto_d;
      ab_was_q   <= ab_was_d;
      grip_q     <= grip_d;
      both_was_q <= both_was_d;
    end
  end

  jsj_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_no_move_in_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.move_request && out_data_o.auto_active))
    else $error("targets stepped while auto mode active");

  a_auto_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.auto_button && !ab_was_q) |=> (auto_q != $past(auto_q)))
    else $error("auto button edge did not toggle auto mode");

  a_estop_holds_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.emergency_stop && (wait_q == '0)) |=> (wait_q == '0))
    else $error("period timer restarted under emergency stop");

  a_idle_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> ($stable(wait_q) && $stable(grip_q) && $stable(auto_q)))
    else $error("state changed without an input transaction");

endmodule

`default_nettype wire

// File: rtl/core/jsj_out_skid.sv
`default_nettype none

module jsj_out_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire jsj_pkg::out_item_t push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output jsj_pkg::out_item_t      out_data_o
);
  import jsj_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && out_stall_i) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end
    end else if (!out_stall_i) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held with empty output register");

  a_push_into_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !skid_valid_q && main_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("transaction lost while output stalled");

  a_drain_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid entry not moved forward");

endmodule

`default_nettype wire

// File: tb/sv/joystick_servo_jog_test.sv
`default_nettype none

module joystick_servo_jog_test;
  import jsj_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned AxisMax       = (1 << AxisW) - 1;

  typedef enum int {
    ZONE_MID,
    ZONE_HIGH,
    ZONE_LOW
  } zone_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // arm state as the block should hold it
  logic [AngleW-1:0]  servo_tgt [ServoCount];
  logic [PeriodW-1:0] ticks_left;
  logic               auto_on;
  logic               auto_btn_prev;
  logic               grip_on;
  logic               both_prev;
  logic [AxisW-1:0]   up_th;
  logic [AxisW-1:0]   down_th;
  logic [PeriodW-1:0] period;
  logic [LimitsW-1:0] lo_lim;
  logic [LimitsW-1:0] hi_lim;

  in_item_t  pending_ticks [$];
  out_item_t expected_outputs [$];

  int unsigned ticks_queued    = 0;
  int unsigned results_seen    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned idle_cycles     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned hold_left       = 0;
  bit          hold_req        = 1'b0;
  bit          tick_taken      = 1'b0;
  bit          gen_auto        = 1'b0;
  bit          gen_ab_prev     = 1'b0;

  joystick_servo_jog u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void step_servo(int unsigned idx, bit up);
    int v;
    int lo;
    int hi;
    v  = int'(servo_tgt[idx]) + (up ? 1 : -1);
    lo = int'(lo_lim[idx*AngleW +: AngleW]);
    hi = int'(hi_lim[idx*AngleW +: AngleW]);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    servo_tgt[idx] = AngleW'(v);
  endfunction

  function automatic bit axis_step(int unsigned idx, logic [AxisW-1:0] val, bit up_when_high);
    if (val > up_th) begin
      step_servo(idx, up_when_high);
      return 1'b1;
    end
    if (val < down_th) begin
      step_servo(idx, !up_when_high);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_tick(in_item_t t);
    out_item_t r;
    bit        moved;
    bit        both;
    r     = '0;
    moved = 1'b0;
    both  = t.left_button && t.right_button;
    if (t.auto_button && !auto_btn_prev) auto_on = !auto_on;
    auto_btn_prev = t.auto_button;
    if (!t.auto_button && !auto_on && ticks_left == '0 && !t.emergency_stop) begin
      ticks_left = (period == '0) ? '0 : period - 1'b1;
      if (axis_step(0, t.left_x, 1'b1)) moved = 1'b1;
      if (axis_step(1, t.left_y, 1'b0)) moved = 1'b1;
      if (axis_step(2, t.right_y, 1'b1)) moved = 1'b1;
      if (axis_step(3, t.right_x, 1'b1)) moved = 1'b1;
      if (both && !both_prev) grip_on = !grip_on;
      both_prev = both;
      if (!both) begin
        if (!grip_on) begin
          if (t.right_button) begin
            step_servo(4, 1'b1);
            moved = 1'b1;
          end else if (t.left_button) begin
            step_servo(4, 1'b0);
            moved = 1'b1;
          end
        end else begin
          if (t.left_button) begin
            step_servo(5, 1'b1);
            moved = 1'b1;
          end else if (t.right_button) begin
            step_servo(5, 1'b0);
            moved = 1'b1;
          end
        end
      end
    end else if (ticks_left != '0) begin
      ticks_left = ticks_left - 1'b1;
    end
    r.target_0              = servo_tgt[0];
    r.target_1              = servo_tgt[1];
    r.target_2              = servo_tgt[2];
    r.target_3              = servo_tgt[3];
    r.target_4              = servo_tgt[4];
    r.target_5              = servo_tgt[5];
    r.move_request          = moved;
    r.auto_active           = auto_on;
    r.buttons_drive_gripper = grip_on;
    return r;
  endfunction

  task automatic report_field(string name, logic [AngleW-1:0] want, logic [AngleW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_output(out_item_t got);
    out_item_t want;
    if (expected_outputs.size() == 0) begin
      $display("%0t: result expected none actual %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_outputs.pop_front();
    report_field("target_0", want.target_0, got.target_0);
    report_field("target_1", want.target_1, got.target_1);
    report_field("target_2", want.target_2, got.target_2);
    report_field("target_3", want.target_3, got.target_3);
    report_field("target_4", want.target_4, got.target_4);
    report_field("target_5", want.target_5, got.target_5);
    report_field("move_request", want.move_request, got.move_request);
    report_field("auto_active", want.auto_active, got.auto_active);
    report_field("buttons_drive_gripper", want.buttons_drive_gripper,
                 got.buttons_drive_gripper);
  endtask

  always @(posedge clk) begin
    tick_taken = in_valid && !in_stall;
    if (tick_taken) expected_outputs.push_back(predict_tick(in_data));
    if (out_valid && !out_stall) begin
      results_seen++;
      check_output(out_data);
    end
    if (tick_taken || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
  end

  always @(negedge clk) begin
    if (!in_valid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("joystick_servo_jog_test NOT OK");
    $finish;
  end

  function automatic in_item_t make_tick(int lx, int ly, int rx, int ry,
                                         bit lb, bit rb, bit ab, bit es);
    in_item_t t;
    t.left_x         = AxisW'(lx);
    t.left_y         = AxisW'(ly);
    t.right_x        = AxisW'(rx);
    t.right_y        = AxisW'(ry);
    t.left_button    = lb;
    t.right_button   = rb;
    t.auto_button    = ab;
    t.emergency_stop = es;
    return t;
  endfunction

  task automatic push_tick(in_item_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
    if (t.auto_button && !gen_ab_prev) gen_auto = !gen_auto;
    gen_ab_prev = t.auto_button;
  endtask

  function automatic int axis_in_zone(zone_e zone);
    if (zone == ZONE_HIGH && up_th < AxisMax) return $urandom_range(up_th + 1, AxisMax);
    if (zone == ZONE_LOW && down_th > 0) return $urandom_range(0, down_th - 1);
    if (down_th <= up_th) return $urandom_range(down_th, up_th);
    return $urandom_range(0, AxisMax);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HIGH_THRESHOLD: up_th   = val[AxisW-1:0];
      CFG_LOW_THRESHOLD:  down_th = val[AxisW-1:0];
      CFG_UPDATE_PERIOD:  period  = val[PeriodW-1:0];
      CFG_MIN_ANGLES:     lo_lim  = val[LimitsW-1:0];
      CFG_MAX_ANGLES:     hi_lim  = val[LimitsW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [AxisW-1:0] hi, logic [AxisW-1:0] lo,
                              logic [PeriodW-1:0] per, logic [LimitsW-1:0] mn,
                              logic [LimitsW-1:0] mx);
    write_reg(CFG_HIGH_THRESHOLD, CfgDataW'(hi));
    write_reg(CFG_LOW_THRESHOLD, CfgDataW'(lo));
    write_reg(CFG_UPDATE_PERIOD, CfgDataW'(per));
    write_reg(CFG_MIN_ANGLES, CfgDataW'(mn));
    write_reg(CFG_MAX_ANGLES, CfgDataW'(mx));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (results_seen != ticks_queued) @(negedge clk);
  endtask

  // mostly held stick gestures, some raw noise, auto toggles kept paired
  task automatic queue_random(int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    zone_e       zl [4];
    bit          lb;
    bit          rb;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 15) begin
        push_tick(make_tick($urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                            $urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                            $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0));
        sent++;
      end else begin
        if (gen_auto || $urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            push_tick(make_tick($urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                                $urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                                $urandom_range(0, 1), $urandom_range(0, 1), 1'b1, 1'b0));
            sent++;
          end
        end
        for (int i = 0; i < 4; i++) zl[i] = zone_e'($urandom_range(0, 2));
        pick = $urandom_range(0, 4);
        lb   = (pick == 2 || pick == 4);
        rb   = (pick == 3 || pick == 4);
        len  = $urandom_range(1, 40);
        repeat (len) begin
          push_tick(make_tick(axis_in_zone(zl[0]), axis_in_zone(zl[1]),
                              axis_in_zone(zl[2]), axis_in_zone(zl[3]),
                              lb, rb, 1'b0, $urandom_range(0, 19) == 0));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct,
                           int unsigned n, bit with_hold);
    sender_idle_pct = snd_pct;
    recv_idle_pct   = rcv_pct;
    queue_random(n);
    if (with_hold) hold_req = 1'b1;
    wait_results();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < ServoCount; i++) servo_tgt[i] = TargetReset;
    ticks_left    = '0;
    auto_on       = 1'b0;
    auto_btn_prev = 1'b0;
    grip_on       = 1'b1;
    both_prev     = 1'b0;
    up_th         = HighThReset;
    down_th       = LowThReset;
    period        = PeriodReset;
    lo_lim        = MinAnglesRst;
    hi_lim        = MaxAnglesRst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 9;
    recv_idle_pct   = 67;

    // reset settings: one evaluation, then a full period of random sticks
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 1'b1, 1'b0, 1'b0, 1'b0));
    repeat (39) begin
      push_tick(make_tick($urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                          $urandom_range(0, AxisMax), $urandom_range(0, AxisMax),
                          $urandom_range(0, 1), $urandom_range(0, 1), 1'b0, 1'b0));
    end
    wait_results();

    apply_config(HighThReset, LowThReset, PeriodW'(1), MinAnglesRst, MaxAnglesRst);
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 0, 0));
    push_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    push_tick(make_tick(3000, 1000, 3000, 1000, 0, 0, 0, 0));
    push_tick(make_tick(3001, 999, 999, 3001, 0, 0, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 1, 0, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 0, 1, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 1, 1, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 1, 1, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 0, 1, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 1, 0, 0, 0));
    push_tick(make_tick(2048, 2048, 2048, 2048, 1, 1, 0, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 1, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 1, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 0, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 1, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 0, 0, 0, 0));
    push_tick(make_tick(AxisMax, AxisMax, AxisMax, AxisMax, 1, 0, 0, 1));
    wait_results();

    // stop holds the timer at zero, so release evaluates at once
    apply_config(HighThReset, LowThReset, PeriodW'(3), MinAnglesRst, MaxAnglesRst);
    push_tick(make_tick(AxisMax, 0, AxisMax, 0, 0, 0, 0, 0));
    repeat (3) push_tick(make_tick(AxisMax, 0, AxisMax, 0, 0, 0, 0, 1));
    push_tick(make_tick(AxisMax, 0, AxisMax, 0, 0, 1, 0, 0));
    push_tick(make_tick(AxisMax, 0, AxisMax, 0, 0, 1, 0, 0));
    wait_results();

    apply_config(HighThReset, LowThReset, PeriodW'(1), '0, {ServoCount{8'hFF}});
    run_phase(9, 67, 250, 1'b1);

    apply_config(AxisW'($urandom), AxisW'($urandom), PeriodW'($urandom_range(1, 4)),
                 LimitsW'({$urandom, $urandom}), LimitsW'({$urandom, $urandom}));
    run_phase(9, 67, 250, 1'b0);

    apply_config('0, AxisW'(AxisMax), '0, {ServoCount{8'hFF}}, '0);
    run_phase(67, 9, 200, 1'b1);

    apply_config(AxisW'(AxisMax), '0, PeriodW'(2), '0, {ServoCount{8'hFF}});
    run_phase(67, 9, 200, 1'b0);

    apply_config(AxisW'(2048), AxisW'(2048), PeriodW'(1), '0, {ServoCount{8'hFF}});
    run_phase(0, 0, 300, 1'b1);

    apply_config(AxisW'($urandom), AxisW'($urandom), PeriodW'(1),
                 LimitsW'({$urandom, $urandom}) & {ServoCount{8'h5F}},
                 LimitsW'({$urandom, $urandom}) | {ServoCount{8'hA0}});
    run_phase(0, 0, 250, 1'b0);

    // longest period last: the timer would not expire again within this run
    apply_config(HighThReset, LowThReset, '1, MinAnglesRst, MaxAnglesRst);
    run_phase(0, 0, 100, 1'b0);

    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("joystick_servo_jog_test OK");
    end else begin
      $display("joystick_servo_jog_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: joystick_servo_jog.f
rtl/core/jsj_pkg.sv
rtl/core/jsj_out_skid.sv
rtl/core/joystick_servo_jog.sv
tb/sv/joystick_servo_jog_test.sv
